// ===== hdl/vgpb_pkg.sv =====
package vgpb_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_CELLS_DEF  = 4096;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths.
  localparam int DATA_W    = 32;
  localparam int DIM_W     = 8;
  localparam int DXY_W     = 2 * DIM_W;
  localparam int NCELL_W   = 3 * DIM_W;
  localparam int GRID_W    = 3 * DIM_W;
  localparam int FUNC_W    = 2;
  localparam int RIDX_W    = 12;
  localparam int STATUS_W  = 3;
  localparam int OIDX_W    = 12;
  localparam int OCNT_W    = 16;
  localparam int CFG_AW    = 5;
  localparam int AXIS_W    = 2;
  localparam int N_AXES    = 3;

  localparam logic [DATA_W-1:0] INV_CELL_RST = 32'd65536;
  localparam logic [GRID_W-1:0] GRID_RST     = 24'h101010;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OUTSIDE   = 3'd1,
    ST_EXPIRED   = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_MIN_X  = 3'd0,
    REG_MIN_Y  = 3'd1,
    REG_MIN_Z  = 3'd2,
    REG_INV_X  = 3'd3,
    REG_INV_Y  = 3'd4,
    REG_INV_Z  = 3'd5,
    REG_GRID   = 3'd6,
    REG_EXPIRE = 3'd7
  } reg_e;

  typedef enum logic [3:0] {
    S_INIT_CLR,
    S_IDLE,
    S_PREP,
    S_GRID,
    S_DISPATCH,
    S_AX_SUB,
    S_AX_MUL,
    S_AX_CHK,
    S_MEM_RD,
    S_MEM_USE,
    S_OP_CLR,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] min_x;
    logic signed [DATA_W-1:0] min_y;
    logic signed [DATA_W-1:0] min_z;
    logic [DATA_W-1:0]        inv_x;
    logic [DATA_W-1:0]        inv_y;
    logic [DATA_W-1:0]        inv_z;
    logic [GRID_W-1:0]        grid_dims;
    logic [DATA_W-1:0]        expire_time;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] coord_x;
    logic signed [DATA_W-1:0] coord_y;
    logic signed [DATA_W-1:0] coord_z;
    logic [DATA_W-1:0]        point_time;
    logic [DATA_W-1:0]        now_time;
    logic [RIDX_W-1:0]        read_index;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OIDX_W-1:0]   cell_index;
    logic [OCNT_W-1:0]   cell_count;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              capture;
    logic              prep;
    logic              grid;
    logic              clr_start;
    logic              clr_wr;
    logic              ax_sub;
    logic              ax_mul;
    logic              ax_chk;
    logic              mem_rd;
    logic              mem_use;
    logic              res_zero;
    status_e           res_status;
    logic              out_load;
    logic [AXIS_W-1:0] axis;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              expired;
    logic              grid_ok;
    logic              ri_ok;
    logic              d_neg;
    logic              ci_ok;
    logic              lin_ok;
    logic              clr_last;
    logic              out_free;
  } sts_t;

endpackage

// ===== hdl/vgpb_item_if.sv =====
interface vgpb_item_if;
  logic                                 valid;
  logic                                 ready;
  logic [vgpb_pkg::FUNC_W-1:0]          func;
  logic signed [vgpb_pkg::DATA_W-1:0]   coord_x;
  logic signed [vgpb_pkg::DATA_W-1:0]   coord_y;
  logic signed [vgpb_pkg::DATA_W-1:0]   coord_z;
  logic [vgpb_pkg::DATA_W-1:0]          point_time;
  logic [vgpb_pkg::DATA_W-1:0]          now_time;
  logic [vgpb_pkg::RIDX_W-1:0]          read_index;

  modport source (
    output valid, func, coord_x, coord_y, coord_z, point_time, now_time, read_index,
    input  ready
  );
  modport sink (
    input  valid, func, coord_x, coord_y, coord_z, point_time, now_time, read_index,
    output ready
  );
endinterface

// ===== hdl/vgpb_result_if.sv =====
interface vgpb_result_if;
  logic                          valid;
  logic                          ready;
  logic [vgpb_pkg::STATUS_W-1:0] status;
  logic [vgpb_pkg::OIDX_W-1:0]   cell_index;
  logic [vgpb_pkg::OCNT_W-1:0]   cell_count;

  modport source (
    output valid, status, cell_index, cell_count,
    input  ready
  );
  modport sink (
    input  valid, status, cell_index, cell_count,
    output ready
  );
endinterface

// ===== hdl/vgpb_regs.sv =====
module vgpb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vgpb_pkg::CFG_AW-1:0]   paddr,
  input  logic [vgpb_pkg::DATA_W-1:0]   pwdata,
  output logic [vgpb_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output vgpb_pkg::cfg_t                cfg_o
);

  vgpb_pkg::cfg_t cfg_q;
  vgpb_pkg::reg_e sel;
  logic           wr_en;

  assign pready = 1'b1;
  assign sel    = vgpb_pkg::reg_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_x       <= '0;
      cfg_q.min_y       <= '0;
      cfg_q.min_z       <= '0;
      cfg_q.inv_x       <= vgpb_pkg::INV_CELL_RST;
      cfg_q.inv_y       <= vgpb_pkg::INV_CELL_RST;
      cfg_q.inv_z       <= vgpb_pkg::INV_CELL_RST;
      cfg_q.grid_dims   <= vgpb_pkg::GRID_RST;
      cfg_q.expire_time <= '0;
    end else if (wr_en) begin
      unique case (sel)
        vgpb_pkg::REG_MIN_X:  cfg_q.min_x       <= pwdata;
        vgpb_pkg::REG_MIN_Y:  cfg_q.min_y       <= pwdata;
        vgpb_pkg::REG_MIN_Z:  cfg_q.min_z       <= pwdata;
        vgpb_pkg::REG_INV_X:  cfg_q.inv_x       <= pwdata;
        vgpb_pkg::REG_INV_Y:  cfg_q.inv_y       <= pwdata;
        vgpb_pkg::REG_INV_Z:  cfg_q.inv_z       <= pwdata;
        vgpb_pkg::REG_GRID:   cfg_q.grid_dims   <= pwdata[vgpb_pkg::GRID_W-1:0];
        vgpb_pkg::REG_EXPIRE: cfg_q.expire_time <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      vgpb_pkg::REG_MIN_X:  prdata = cfg_q.min_x;
      vgpb_pkg::REG_MIN_Y:  prdata = cfg_q.min_y;
      vgpb_pkg::REG_MIN_Z:  prdata = cfg_q.min_z;
      vgpb_pkg::REG_INV_X:  prdata = cfg_q.inv_x;
      vgpb_pkg::REG_INV_Y:  prdata = cfg_q.inv_y;
      vgpb_pkg::REG_INV_Z:  prdata = cfg_q.inv_z;
      vgpb_pkg::REG_GRID:   prdata = {8'b0, cfg_q.grid_dims};
      vgpb_pkg::REG_EXPIRE: prdata = cfg_q.expire_time;
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== hdl/vgpb_ctrl.sv =====
module vgpb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  vgpb_pkg::sts_t sts_i,
  output logic           in_ready_o,
  output vgpb_pkg::cmd_t cmd_o
);

  vgpb_pkg::state_e                state_q, state_d;
  logic [vgpb_pkg::AXIS_W-1:0]     axis_q, axis_d;
  logic                            axis_last;

  assign axis_last = (axis_q == vgpb_pkg::AXIS_W'(vgpb_pkg::N_AXES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vgpb_pkg::S_INIT_CLR;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    unique case (state_q)
      vgpb_pkg::S_INIT_CLR: begin
        if (sts_i.clr_last) state_d = vgpb_pkg::S_IDLE;
      end
      vgpb_pkg::S_IDLE: begin
        if (in_valid_i) state_d = vgpb_pkg::S_PREP;
      end
      vgpb_pkg::S_PREP:     state_d = vgpb_pkg::S_GRID;
      vgpb_pkg::S_GRID:     state_d = vgpb_pkg::S_DISPATCH;
      vgpb_pkg::S_DISPATCH: begin
        axis_d = '0;
        unique case (sts_i.func)
          vgpb_pkg::FUNC_CLEAR: state_d = vgpb_pkg::S_OP_CLR;
          vgpb_pkg::FUNC_READ: begin
            if (sts_i.grid_ok && sts_i.ri_ok) state_d = vgpb_pkg::S_MEM_RD;
            else state_d = vgpb_pkg::S_RESULT;
          end
          vgpb_pkg::FUNC_ADD: begin
            if (!sts_i.expired && sts_i.grid_ok) state_d = vgpb_pkg::S_AX_SUB;
            else state_d = vgpb_pkg::S_RESULT;
          end
          default: state_d = vgpb_pkg::S_RESULT;
        endcase
      end
      vgpb_pkg::S_AX_SUB:   state_d = vgpb_pkg::S_AX_MUL;
      vgpb_pkg::S_AX_MUL: begin
        if (sts_i.d_neg) state_d = vgpb_pkg::S_RESULT;
        else state_d = vgpb_pkg::S_AX_CHK;
      end
      vgpb_pkg::S_AX_CHK: begin
        if (!sts_i.ci_ok) begin
          state_d = vgpb_pkg::S_RESULT;
        end else if (axis_last) begin
          state_d = vgpb_pkg::S_MEM_RD;
        end else begin
          state_d = vgpb_pkg::S_AX_SUB;
          axis_d  = axis_q + 1'b1;
        end
      end
      vgpb_pkg::S_MEM_RD: begin
        if (sts_i.lin_ok) state_d = vgpb_pkg::S_MEM_USE;
        else state_d = vgpb_pkg::S_RESULT;
      end
      vgpb_pkg::S_MEM_USE:  state_d = vgpb_pkg::S_RESULT;
      vgpb_pkg::S_OP_CLR: begin
        if (sts_i.clr_last) state_d = vgpb_pkg::S_RESULT;
      end
      vgpb_pkg::S_RESULT: begin
        if (sts_i.out_free) state_d = vgpb_pkg::S_IDLE;
      end
      default: state_d = vgpb_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = vgpb_pkg::ST_OK;
    cmd_o.axis       = axis_q;
    in_ready_o       = 1'b0;
    unique case (state_q)
      vgpb_pkg::S_INIT_CLR: cmd_o.clr_wr = 1'b1;
      vgpb_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      vgpb_pkg::S_PREP:     cmd_o.prep = 1'b1;
      vgpb_pkg::S_GRID:     cmd_o.grid = 1'b1;
      vgpb_pkg::S_DISPATCH: begin
        unique case (sts_i.func)
          vgpb_pkg::FUNC_CLEAR: cmd_o.clr_start = 1'b1;
          vgpb_pkg::FUNC_READ: begin
            if (!sts_i.grid_ok) begin
              cmd_o.res_zero   = 1'b1;
              cmd_o.res_status = vgpb_pkg::ST_TOO_LARGE;
            end else if (!sts_i.ri_ok) begin
              cmd_o.res_zero   = 1'b1;
              cmd_o.res_status = vgpb_pkg::ST_BAD_INDEX;
            end
          end
          vgpb_pkg::FUNC_ADD: begin
            if (sts_i.expired) begin
              cmd_o.res_zero   = 1'b1;
              cmd_o.res_status = vgpb_pkg::ST_EXPIRED;
            end else if (!sts_i.grid_ok) begin
              cmd_o.res_zero   = 1'b1;
              cmd_o.res_status = vgpb_pkg::ST_TOO_LARGE;
            end
          end
          default: begin
            cmd_o.res_zero   = 1'b1;
            cmd_o.res_status = vgpb_pkg::ST_BAD_INDEX;
          end
        endcase
      end
      vgpb_pkg::S_AX_SUB:   cmd_o.ax_sub = 1'b1;
      vgpb_pkg::S_AX_MUL: begin
        if (sts_i.d_neg) begin
          cmd_o.res_zero   = 1'b1;
          cmd_o.res_status = vgpb_pkg::ST_OUTSIDE;
        end else begin
          cmd_o.ax_mul = 1'b1;
        end
      end
      vgpb_pkg::S_AX_CHK: begin
        if (!sts_i.ci_ok) begin
          cmd_o.res_zero   = 1'b1;
          cmd_o.res_status = vgpb_pkg::ST_OUTSIDE;
        end else begin
          cmd_o.ax_chk = 1'b1;
        end
      end
      vgpb_pkg::S_MEM_RD: begin
        if (sts_i.lin_ok) begin
          cmd_o.mem_rd = 1'b1;
        end else begin
          cmd_o.res_zero   = 1'b1;
          cmd_o.res_status = vgpb_pkg::ST_OUTSIDE;
        end
      end
      vgpb_pkg::S_MEM_USE:  cmd_o.mem_use = 1'b1;
      vgpb_pkg::S_OP_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.res_zero   = 1'b1;
          cmd_o.res_status = vgpb_pkg::ST_OK;
        end
      end
      vgpb_pkg::S_RESULT:   cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hdl/vgpb_datapath.sv =====
module vgpb_datapath #(
  parameter int MAX_CELLS  = vgpb_pkg::MAX_CELLS_DEF,
  parameter int COUNT_BITS = vgpb_pkg::COUNT_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vgpb_pkg::cfg_t  cfg_i,
  input  vgpb_pkg::item_t item_i,
  input  vgpb_pkg::cmd_t  cmd_i,
  output vgpb_pkg::sts_t  sts_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output vgpb_pkg::res_t  out_o
);

  localparam int IDX_W = $clog2(MAX_CELLS);

  localparam int DW  = vgpb_pkg::DATA_W;
  localparam int NW  = vgpb_pkg::NCELL_W;
  localparam int MW  = vgpb_pkg::DIM_W;

  // Counter memory.
  logic [COUNT_BITS-1:0] mem [MAX_CELLS];

  // Captured item and per-item working registers.
  vgpb_pkg::item_t       item_q;
  logic [vgpb_pkg::DXY_W-1:0] dxy_q;
  logic [NW-1:0]         ncells_q;
  logic                  expired_q;
  logic [DW:0]           d_q;
  logic [2*DW-1:0]       prod_q;
  logic [NW-1:0]         lin_q;
  logic [IDX_W-1:0]      addr_q;
  logic [COUNT_BITS-1:0] rdata_q;
  vgpb_pkg::res_t        res_q;
  vgpb_pkg::res_t        out_q;
  logic                  out_valid_q;
  logic [IDX_W-1:0]      clr_cnt_q;

  logic [MW-1:0]         dx, dy, dz, dim_sel;
  logic signed [DW-1:0]  coord_sel, min_sel;
  logic [DW-1:0]         inv_sel;
  logic [DW:0]           d_d;
  logic [DW-1:0]         ci;
  logic [DW-1:0]         lin_prod;
  logic [NW-1:0]         lin_d;
  logic [DW:0]           expiry_sum;
  logic [NW-1:0]         ri_ext;
  logic [IDX_W-1:0]      rd_addr;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] cnt_res;
  logic [COUNT_BITS+vgpb_pkg::OCNT_W-1:0] cnt_wide;
  logic [IDX_W+vgpb_pkg::OIDX_W-1:0]      idx_wide;
  logic                  is_add, is_read;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  assign dx = cfg_i.grid_dims[MW-1:0];
  assign dy = cfg_i.grid_dims[2*MW-1:MW];
  assign dz = cfg_i.grid_dims[3*MW-1:2*MW];

  assign is_add  = (item_q.func == vgpb_pkg::FUNC_ADD);
  assign is_read = (item_q.func == vgpb_pkg::FUNC_READ);

  always_comb begin
    unique case (cmd_i.axis)
      2'd0: begin
        coord_sel = item_q.coord_x;
        min_sel   = cfg_i.min_x;
        inv_sel   = cfg_i.inv_x;
        dim_sel   = dx;
      end
      2'd1: begin
        coord_sel = item_q.coord_y;
        min_sel   = cfg_i.min_y;
        inv_sel   = cfg_i.inv_y;
        dim_sel   = dy;
      end
      default: begin
        coord_sel = item_q.coord_z;
        min_sel   = cfg_i.min_z;
        inv_sel   = cfg_i.inv_z;
        dim_sel   = dz;
      end
    endcase
  end

  // Exact 33-bit difference; a set sign bit puts the point below the grid.
  assign d_d        = {coord_sel[DW-1], coord_sel} - {min_sel[DW-1], min_sel};
  assign ci         = prod_q[2*DW-1:DW];
  assign lin_prod   = {{(DW-NW){1'b0}}, lin_q} * {{(DW-MW){1'b0}}, dim_sel};
  assign lin_d      = lin_prod[NW-1:0] + {{(NW-MW){1'b0}}, ci[MW-1:0]};
  assign expiry_sum = {1'b0, item_q.point_time} + {1'b0, cfg_i.expire_time};
  assign ri_ext     = {{(NW-vgpb_pkg::RIDX_W){1'b0}}, item_q.read_index};
  assign rd_addr    = is_read ? ri_ext[IDX_W-1:0] : lin_q[IDX_W-1:0];
  assign cnt_inc    = (&rdata_q) ? rdata_q : rdata_q + COUNT_BITS'(1);
  assign cnt_res    = is_add ? cnt_inc : rdata_q;
  assign cnt_wide   = {{vgpb_pkg::OCNT_W{1'b0}}, cnt_res};
  assign idx_wide   = {{vgpb_pkg::OIDX_W{1'b0}}, addr_q};

  assign mem_we    = cmd_i.clr_wr || (cmd_i.mem_use && is_add);
  assign mem_waddr = cmd_i.clr_wr ? clr_cnt_q : addr_q;
  assign mem_wdata = cmd_i.clr_wr ? '0 : cnt_inc;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.mem_rd) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= item_i;
    if (cmd_i.prep) begin
      dxy_q     <= {{MW{1'b0}}, dx} * {{MW{1'b0}}, dy};
      expired_q <= (cfg_i.expire_time != '0) && (expiry_sum < {1'b0, item_q.now_time});
      lin_q     <= '0;
    end
    if (cmd_i.grid) ncells_q <= {{MW{1'b0}}, dxy_q} * {{(NW-MW){1'b0}}, dz};
    if (cmd_i.ax_sub) d_q <= d_d;
    if (cmd_i.ax_mul) prod_q <= {{DW{1'b0}}, d_q[DW-1:0]} * {{DW{1'b0}}, inv_sel};
    if (cmd_i.ax_chk) lin_q <= lin_d;
    if (cmd_i.mem_rd) addr_q <= rd_addr;
    if (cmd_i.res_zero) begin
      res_q.status     <= cmd_i.res_status;
      res_q.cell_index <= '0;
      res_q.cell_count <= '0;
    end else if (cmd_i.mem_use) begin
      res_q.status     <= vgpb_pkg::ST_OK;
      res_q.cell_index <= idx_wide[vgpb_pkg::OIDX_W-1:0];
      res_q.cell_count <= cnt_wide[vgpb_pkg::OCNT_W-1:0];
    end
    if (cmd_i.out_load) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_start) clr_cnt_q <= '0;
      else if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.func     = item_q.func;
  assign sts_o.expired  = expired_q;
  assign sts_o.grid_ok  = (ncells_q != '0) && (ncells_q <= NW'(MAX_CELLS));
  assign sts_o.ri_ok    = ri_ext < ncells_q;
  assign sts_o.d_neg    = d_q[DW];
  assign sts_o.ci_ok    = ci < {{(DW-MW){1'b0}}, dim_sel};
  assign sts_o.lin_ok   = is_read || (lin_q < NW'(MAX_CELLS));
  assign sts_o.clr_last = (clr_cnt_q == IDX_W'(MAX_CELLS - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== hdl/voxel_grid_point_binning_unit.sv =====
// Voxel grid point binning unit. Each item is an add (bin a Q16.16 point into
// a grid of saturating per-cell hit counters), a clear (zero every counter) or
// a read (return one cell's counter), and each item yields exactly one result.
// Items are handled one at a time by a controller that steps a datapath
// through the work. Every item passes prepare, grid size and dispatch steps.
// An add then runs a subtract, a multiply and a check for each axis (the three
// axes share one 32x32 multiplier) and a read-modify-write of its counter in
// the counter memory, and stops early when the point is rejected; a read goes
// straight to its counter read; a clear writes one counter per cycle. After
// reset the block runs the same clearing pass before it accepts its first
// item; configuration writes are taken throughout. A finished result sits in
// an output register, so the next item is accepted while the result waits to
// be taken.
module voxel_grid_point_binning_unit #(
  parameter int MAX_CELLS  = vgpb_pkg::MAX_CELLS_DEF,
  parameter int COUNT_BITS = vgpb_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  vgpb_item_if.sink                   item_i,
  vgpb_result_if.source               result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vgpb_pkg::CFG_AW-1:0] paddr,
  input  logic [vgpb_pkg::DATA_W-1:0] pwdata,
  output logic [vgpb_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  vgpb_pkg::cfg_t  cfg;
  vgpb_pkg::item_t item;
  vgpb_pkg::cmd_t  cmd;
  vgpb_pkg::sts_t  sts;
  vgpb_pkg::res_t  res;
  logic            in_ready;

  // Register file behind the configuration port.
  vgpb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign item.func       = item_i.func;
  assign item.coord_x    = item_i.coord_x;
  assign item.coord_y    = item_i.coord_y;
  assign item.coord_z    = item_i.coord_z;
  assign item.point_time = item_i.point_time;
  assign item.now_time   = item_i.now_time;
  assign item.read_index = item_i.read_index;
  assign item_i.ready    = in_ready;

  // The controller sequences each item; the datapath holds the counters.
  vgpb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  vgpb_datapath #(
    .MAX_CELLS  (MAX_CELLS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_i      (item),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_o       (res)
  );

  assign result_o.status     = res.status;
  assign result_o.cell_index = res.cell_index;
  assign result_o.cell_count = res.cell_count;

  // A result is never loaded in the cycle right after an item is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !cmd.out_load)
    else $error("result loaded directly after acceptance");

  // A new result never overwrites one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!result_o.valid || result_o.ready))
    else $error("pending result overwritten");

  // The counter update always follows a counter read in the previous cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mem_use |-> $past(cmd.mem_rd))
    else $error("counter update without a preceding read");

  // No item is taken while the clearing pass owns the counter memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !item_i.ready)
    else $error("item accepted during a clearing pass");

endmodule

// ===== tb/sv/tb_voxel_grid_point_binning_unit.sv =====
`timescale 1ns / 1ps

module tb_voxel_grid_point_binning_unit;

  typedef longint unsigned u64_t;

  // The block is built at its default sizes.
  localparam int   MAX_CELLS  = vgpb_pkg::MAX_CELLS_DEF;
  localparam int   COUNT_BITS = vgpb_pkg::COUNT_BITS_DEF;
  localparam u64_t CNT_MAX    = (u64_t'(1) << COUNT_BITS) - 1;

  // The func code that the package leaves without a name.
  localparam logic [vgpb_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // A clear walks every counter, so the quiet limit must cover a full clearing
  // pass plus the long receiver hold, with a wide margin.
  localparam int QUIET_LIMIT = 40000;
  localparam int HOLD_CYCLES = 600;
  localparam int HIST_DEPTH  = 32;

  logic                            clk_i  = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [vgpb_pkg::CFG_AW-1:0]     paddr;
  logic [vgpb_pkg::DATA_W-1:0]     pwdata;
  logic [vgpb_pkg::DATA_W-1:0]     prdata;
  logic                            pready;

  vgpb_item_if   point_bus ();
  vgpb_result_if bin_bus ();

  voxel_grid_point_binning_unit #(
    .MAX_CELLS (MAX_CELLS),
    .COUNT_BITS(COUNT_BITS)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (point_bus),
    .result_o(bin_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Our own copy of the grid setup and of the hit counters.
  logic signed [vgpb_pkg::DATA_W-1:0] corner_m [vgpb_pkg::N_AXES];
  logic [vgpb_pkg::DATA_W-1:0]        inv_m [vgpb_pkg::N_AXES];
  logic [vgpb_pkg::GRID_W-1:0]        dims_m;
  logic [vgpb_pkg::DATA_W-1:0]        expire_m;
  logic [COUNT_BITS-1:0]              hits_m [MAX_CELLS];

  vgpb_pkg::item_t             pending_points [$];
  vgpb_pkg::res_t              expected_bins [$];
  logic [vgpb_pkg::RIDX_W-1:0] recent_cells [$];

  vgpb_pkg::item_t on_bus;
  vgpb_pkg::res_t  want;
  bit              offering;
  int unsigned     send_idle_pct;
  int unsigned     take_stall_pct;
  int              phase_no;
  int              hold_phase;
  int              hold_served;
  int              hold_left;
  int              quiet_cycles;
  int              fail_cnt;

  function automatic int unsigned axis_dim(int a);
    return int'(dims_m[a*vgpb_pkg::DIM_W +: vgpb_pkg::DIM_W]);
  endfunction

  function automatic bit grid_fits();
    int unsigned nc;
    nc = axis_dim(0) * axis_dim(1) * axis_dim(2);
    return nc != 0 && nc <= MAX_CELLS;
  endfunction

  // Maps a point to its linear cell; returns 0 when any axis falls outside.
  function automatic bit locate_cell(input vgpb_pkg::item_t it, output int unsigned lin);
    logic signed [vgpb_pkg::DATA_W-1:0] crd [vgpb_pkg::N_AXES];
    longint                             d;
    u64_t                               ci [vgpb_pkg::N_AXES];
    int                                 a;
    crd[0] = it.coord_x;
    crd[1] = it.coord_y;
    crd[2] = it.coord_z;
    lin = 0;
    for (a = 0; a < vgpb_pkg::N_AXES; a++) begin
      // The difference is exact, so a wrap of the 32-bit inputs cannot hide it.
      d = longint'(crd[a]) - longint'(corner_m[a]);
      if (d < 0) return 1'b0;
      ci[a] = (u64_t'(d) * u64_t'(inv_m[a])) >> 32;
      if (ci[a] >= axis_dim(a)) return 1'b0;
    end
    lin = 32'(ci[0] * axis_dim(1) * axis_dim(2) + ci[1] * axis_dim(2) + ci[2]);
    return 1'b1;
  endfunction

  // Works out the result of one accepted item and updates the counters.
  function automatic vgpb_pkg::res_t bin_point(input vgpb_pkg::item_t it);
    vgpb_pkg::res_t r;
    int unsigned    lin;
    int             i;
    r = '0;
    case (it.func)
      vgpb_pkg::FUNC_CLEAR: begin
        for (i = 0; i < MAX_CELLS; i++) hits_m[i] = '0;
        r.status = vgpb_pkg::ST_OK;
      end
      vgpb_pkg::FUNC_READ: begin
        if (!grid_fits()) begin
          r.status = vgpb_pkg::ST_TOO_LARGE;
        end else if (it.read_index >= axis_dim(0) * axis_dim(1) * axis_dim(2)) begin
          r.status = vgpb_pkg::ST_BAD_INDEX;
        end else begin
          r.status     = vgpb_pkg::ST_OK;
          r.cell_index = it.read_index;
          r.cell_count = hits_m[it.read_index];
        end
      end
      vgpb_pkg::FUNC_ADD: begin
        // Age is checked on 33 bits so that a late timestamp never wraps.
        if (expire_m != '0 &&
            ({1'b0, it.point_time} + {1'b0, expire_m}) < {1'b0, it.now_time}) begin
          r.status = vgpb_pkg::ST_EXPIRED;
        end else if (!grid_fits()) begin
          r.status = vgpb_pkg::ST_TOO_LARGE;
        end else if (!locate_cell(it, lin)) begin
          r.status = vgpb_pkg::ST_OUTSIDE;
        end else begin
          if (hits_m[lin] < CNT_MAX) hits_m[lin] = hits_m[lin] + 1'b1;
          r.status     = vgpb_pkg::ST_OK;
          r.cell_index = lin[vgpb_pkg::OIDX_W-1:0];
          r.cell_count = hits_m[lin];
        end
      end
      default: begin
        r.status = vgpb_pkg::ST_BAD_INDEX;
      end
    endcase
    return r;
  endfunction

  // Point coordinate for one axis: mostly inside the grid, some just below
  // the lower corner, some just past the far edge, and some anywhere.
  function automatic logic [vgpb_pkg::DATA_W-1:0] pick_coord(int a);
    u64_t        span;
    u64_t        d;
    int unsigned r;
    r    = $urandom_range(0, 99);
    span = (u64_t'(axis_dim(a)) << 32) / u64_t'(inv_m[a]);
    if (span > 64'h1_0000_0000) span = 64'h1_0000_0000;
    if (span == 0 || r < 6) return $urandom;
    if (r < 11) return corner_m[a] - $urandom_range(1, 32'h0002_0000);
    if (r < 16) d = span + $urandom_range(0, 32'h0002_0000);
    else d = {$urandom, $urandom} % span;
    return corner_m[a] + d[vgpb_pkg::DATA_W-1:0];
  endfunction

  // Returns {point_time, now_time}. With expiry on, most points are fresh,
  // a share is stale, and both sides of the age boundary are hit exactly.
  function automatic logic [2*vgpb_pkg::DATA_W-1:0] pick_times();
    logic [vgpb_pkg::DATA_W-1:0] pt;
    logic [vgpb_pkg::DATA_W-1:0] now;
    u64_t                        hi;
    int unsigned                 r;
    r   = $urandom_range(0, 99);
    pt  = $urandom;
    now = $urandom;
    if (expire_m != '0 && r >= 15) begin
      if (r < 40 && expire_m != '1) begin
        hi  = 64'hFFFF_FFFE - expire_m;
        pt  = $urandom_range(0, hi[vgpb_pkg::DATA_W-1:0]);
        now = (r < 22) ? pt + expire_m + 1'b1
                       : $urandom_range(pt + expire_m + 1'b1, 32'hFFFF_FFFF);
      end else if (r < 50) begin
        now = pt + expire_m;
      end else begin
        now = pt + $urandom_range(0, expire_m);
      end
    end
    return {pt, now};
  endfunction

  // Read index: often a cell that was recently hit, else any valid cell,
  // now and then any 12-bit value.
  function automatic logic [vgpb_pkg::RIDX_W-1:0] pick_cell();
    int unsigned r;
    int unsigned nc;
    int unsigned v;
    r  = $urandom_range(0, 99);
    nc = axis_dim(0) * axis_dim(1) * axis_dim(2);
    if (r < 50 && recent_cells.size() != 0)
      return recent_cells[$urandom_range(0, recent_cells.size() - 1)];
    if (r < 90 && nc != 0 && nc <= MAX_CELLS) v = $urandom_range(0, nc - 1);
    else v = $urandom_range(0, 4095);
    return v[vgpb_pkg::RIDX_W-1:0];
  endfunction

  function automatic vgpb_pkg::item_t point_item(input logic [vgpb_pkg::DATA_W-1:0] x, y, z,
                                                 pt, now);
    vgpb_pkg::item_t it;
    int unsigned     ri;
    ri            = $urandom_range(0, 4095);
    it.func       = vgpb_pkg::FUNC_ADD;
    it.coord_x    = x;
    it.coord_y    = y;
    it.coord_z    = z;
    it.point_time = pt;
    it.now_time   = now;
    it.read_index = ri[vgpb_pkg::RIDX_W-1:0];
    return it;
  endfunction

  function automatic vgpb_pkg::item_t op_item(input logic [vgpb_pkg::FUNC_W-1:0] f,
                                              input logic [vgpb_pkg::RIDX_W-1:0] idx);
    vgpb_pkg::item_t it;
    it            = point_item($urandom, $urandom, $urandom, $urandom, $urandom);
    it.func       = f;
    it.read_index = idx;
    return it;
  endfunction

  // Appends one item to the sender's queue.
  function automatic void queue_point(input vgpb_pkg::item_t it);
    pending_points.insert(pending_points.size(), it);
  endfunction

  // One register write: a setup cycle, then an access cycle that completes
  // at the edge where pready is seen high.
  task automatic cfg_write(input vgpb_pkg::reg_e idx, input logic [vgpb_pkg::DATA_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      vgpb_pkg::REG_MIN_X:  corner_m[0] = val;
      vgpb_pkg::REG_MIN_Y:  corner_m[1] = val;
      vgpb_pkg::REG_MIN_Z:  corner_m[2] = val;
      vgpb_pkg::REG_INV_X:  inv_m[0]    = val;
      vgpb_pkg::REG_INV_Y:  inv_m[1]    = val;
      vgpb_pkg::REG_INV_Z:  inv_m[2]    = val;
      vgpb_pkg::REG_GRID:   dims_m      = val[vgpb_pkg::GRID_W-1:0];
      default:              expire_m    = val;
    endcase
  endtask

  task automatic apply_setup(input logic [vgpb_pkg::DATA_W-1:0] mx, my, mz, ix, iy, iz,
                             input logic [vgpb_pkg::GRID_W-1:0] dims,
                             input logic [vgpb_pkg::DATA_W-1:0] ex);
    cfg_write(vgpb_pkg::REG_MIN_X, mx);
    cfg_write(vgpb_pkg::REG_MIN_Y, my);
    cfg_write(vgpb_pkg::REG_MIN_Z, mz);
    cfg_write(vgpb_pkg::REG_INV_X, ix);
    cfg_write(vgpb_pkg::REG_INV_Y, iy);
    cfg_write(vgpb_pkg::REG_INV_Z, iz);
    cfg_write(vgpb_pkg::REG_GRID, {{(vgpb_pkg::DATA_W-vgpb_pkg::GRID_W){1'b0}}, dims});
    cfg_write(vgpb_pkg::REG_EXPIRE, ex);
    recent_cells.delete();
  endtask

  // Picks the idling mix for the next stretch of items.
  task automatic begin_phase(input int mode);
    phase_no++;
    case (mode % 4)
      0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
      1: begin send_idle_pct = 49; take_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  take_stall_pct = 49; end
      default: begin send_idle_pct = 15; take_stall_pct = 15; end
    endcase
  endtask

  // A floor of 26 or more on the mix yields adds only.
  task automatic push_random(input int n, input int unsigned mix_floor);
    vgpb_pkg::item_t                 it;
    int unsigned                     r;
    int unsigned                     lin;
    logic [2*vgpb_pkg::DATA_W-1:0]   tm;
    repeat (n) begin
      tm = pick_times();
      it = point_item($urandom, $urandom, $urandom,
                      tm[2*vgpb_pkg::DATA_W-1:vgpb_pkg::DATA_W], tm[vgpb_pkg::DATA_W-1:0]);
      r  = $urandom_range(mix_floor, 99);
      if (r < 1) begin
        it.func = vgpb_pkg::FUNC_CLEAR;
      end else if (r < 4) begin
        it.func = FUNC_UNUSED;
      end else if (r < 26) begin
        it.func       = vgpb_pkg::FUNC_READ;
        it.read_index = pick_cell();
      end else begin
        it.coord_x = pick_coord(0);
        it.coord_y = pick_coord(1);
        it.coord_z = pick_coord(2);
        if (grid_fits() && locate_cell(it, lin)) begin
          recent_cells.insert(recent_cells.size(), lin[vgpb_pkg::RIDX_W-1:0]);
          if (recent_cells.size() > HIST_DEPTH) void'(recent_cells.pop_front());
        end
      end
      queue_point(it);
    end
  endtask

  // Every item yields a result, so once nothing is queued, offered or
  // expected the block is idle; the wait after that covers the output register.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_points.size() != 0 || offering || expected_bins.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Sender: predicts each item at the edge where it is taken, then offers
  // the next queued item unless this cycle is chosen to idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (point_bus.valid && point_bus.ready) begin
        expected_bins.insert(expected_bins.size(), bin_point(on_bus));
      end
      if (!point_bus.valid || point_bus.ready) begin
        if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus               = pending_points.pop_front();
          offering             = 1'b1;
          point_bus.valid      <= 1'b1;
          point_bus.func       <= on_bus.func;
          point_bus.coord_x    <= on_bus.coord_x;
          point_bus.coord_y    <= on_bus.coord_y;
          point_bus.coord_z    <= on_bus.coord_z;
          point_bus.point_time <= on_bus.point_time;
          point_bus.now_time   <= on_bus.now_time;
          point_bus.read_index <= on_bus.read_index;
        end else begin
          offering        = 1'b0;
          point_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each taken result against the oldest prediction and
  // stalls at random. A long hold, when requested, keeps ready low so that
  // the output register fills and the block stops taking items.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (bin_bus.valid && bin_bus.ready) begin
        if (expected_bins.size() == 0) begin
          $error("result with no item outstanding: status %0d, cell_index %0d, cell_count %0d",
                 bin_bus.status, bin_bus.cell_index, bin_bus.cell_count);
          fail_cnt++;
        end else begin
          want = expected_bins.pop_front();
          if (bin_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, bin_bus.status);
            fail_cnt++;
          end
          if (bin_bus.cell_index !== want.cell_index) begin
            $error("cell_index: expected %0d, got %0d", want.cell_index, bin_bus.cell_index);
            fail_cnt++;
          end
          if (bin_bus.cell_count !== want.cell_count) begin
            $error("cell_count: expected %0d, got %0d", want.cell_count, bin_bus.cell_count);
            fail_cnt++;
          end
        end
      end
      if (hold_phase != hold_served) begin
        hold_served = hold_phase;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        bin_bus.ready <= 1'b0;
      end else begin
        bin_bus.ready <= ($urandom_range(0, 99) >= take_stall_pct);
      end
    end
  end

  // Watchdog: too long without any item or result moving means a hang.
  always @(posedge clk_i) begin
    if ((point_bus.valid && point_bus.ready) || (bin_bus.valid && bin_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int a;
    point_bus.valid      = 1'b0;
    point_bus.func       = vgpb_pkg::FUNC_ADD;
    point_bus.coord_x    = '0;
    point_bus.coord_y    = '0;
    point_bus.coord_z    = '0;
    point_bus.point_time = '0;
    point_bus.now_time   = '0;
    point_bus.read_index = '0;
    bin_bus.ready        = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    offering             = 1'b0;
    phase_no             = 0;
    hold_phase           = 0;
    hold_served          = 0;
    hold_left            = 0;
    quiet_cycles         = 0;
    fail_cnt             = 0;
    send_idle_pct        = 0;
    take_stall_pct       = 0;
    for (a = 0; a < vgpb_pkg::N_AXES; a++) begin
      corner_m[a] = '0;
      inv_m[a]    = vgpb_pkg::INV_CELL_RST;
    end
    dims_m   = vgpb_pkg::GRID_RST;
    expire_m = '0;
    for (a = 0; a < MAX_CELLS; a++) hits_m[a] = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setup: 16x16x16 cells of unit size at the origin, no expiry.
    // Both corners of the grid, one step past the far edge, the extremes of
    // a coordinate, reads of hit and untouched cells, the unused func code
    // and a clear.
    begin_phase(0);
    queue_point(point_item(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0));
    queue_point(point_item(32'h000F_FFFF, 32'h000F_FFFF, 32'h000F_FFFF,
                           32'h0, 32'hFFFF_FFFF));
    queue_point(point_item(32'h000F_FFFF, 32'h000F_FFFF, 32'h000F_FFFF,
                           $urandom, $urandom));
    queue_point(point_item(32'h0010_0000, 32'h0, 32'h0, $urandom, $urandom));
    queue_point(point_item(32'hFFFF_FFFF, 32'h0, 32'h0, $urandom, $urandom));
    queue_point(point_item(32'h0, 32'h7FFF_FFFF, 32'h0, $urandom, $urandom));
    queue_point(point_item(32'h0, 32'h0, 32'h8000_0000, $urandom, $urandom));
    queue_point(op_item(vgpb_pkg::FUNC_READ, 12'd0));
    queue_point(op_item(vgpb_pkg::FUNC_READ, 12'd4095));
    queue_point(op_item(vgpb_pkg::FUNC_READ, 12'd1));
    queue_point(op_item(FUNC_UNUSED, 12'd0));
    queue_point(op_item(vgpb_pkg::FUNC_CLEAR, 12'd4095));
    queue_point(op_item(vgpb_pkg::FUNC_READ, 12'd4095));
    wait_drained();

    // Empty grid with expiry on: an expired point reports expiry even though
    // the grid is unusable, the age boundary is exact and does not wrap, and
    // a clear still works.
    begin_phase(1);
    apply_setup(32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 24'h000000, 32'd100);
    queue_point(point_item(32'h0, 32'h0, 32'h0, 32'd1000, 32'd1100));
    queue_point(point_item(32'h0, 32'h0, 32'h0, 32'd1000, 32'd1101));
    queue_point(point_item(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0));
    queue_point(op_item(vgpb_pkg::FUNC_READ, 12'd0));
    queue_point(op_item(vgpb_pkg::FUNC_CLEAR, 12'd0));
    queue_point(op_item(FUNC_UNUSED, 12'd7));
    wait_drained();

    // 4x4x4 grid with a negative corner and half-unit cells; expiry at its
    // largest can never fire. Reads just past the last cell are bad indexes.
    begin_phase(2);
    apply_setup(32'hFFFE_0000, 32'hFFFF_8000, 32'h0, 32'h2_0000, 32'h2_0000, 32'h2_0000,
                24'h040404, 32'hFFFF_FFFF);
    queue_point(op_item(vgpb_pkg::FUNC_READ, 12'd64));
    queue_point(op_item(vgpb_pkg::FUNC_READ, 12'd63));
    queue_point(op_item(vgpb_pkg::FUNC_READ, 12'd4095));
    queue_point(point_item(32'hFFFE_0000, 32'hFFFF_8000, 32'h0,
                           32'h0, 32'hFFFF_FFFF));
    queue_point(point_item(32'hFFFF_FFFF, 32'h0001_7FFF, 32'h0001_FFFF,
                           32'h0, 32'hFFFF_FFFF));
    push_random(300, 0);
    wait_drained();

    // Full 16x16x16 grid at a random corner and scale; the receiver holds
    // off for a long stretch while items keep coming.
    begin_phase(0);
    apply_setup($urandom_range(0, 32'h00C8_0000) - 32'h0064_0000,
                $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000,
                $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000,
                $urandom_range(32'h4000, 32'h4_0000), $urandom_range(32'h4000, 32'h4_0000),
                $urandom_range(32'h4000, 32'h4_0000), 24'h101010, 32'd1000);
    push_random(300, 0);
    hold_phase = phase_no;
    wait_drained();

    // A single cell: a run of adds piles up on one counter.
    begin_phase(3);
    apply_setup(32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 24'h010101, 32'h0);
    push_random(80, 26);
    push_random(120, 0);
    wait_drained();

    // Extreme setup: lowest and highest corners, smallest and largest
    // inverse cell sizes, a 255-cell axis, and the shortest expiry.
    begin_phase(1);
    apply_setup(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h3_0000,
                24'h1001FF, 32'd1);
    push_random(300, 0);
    wait_drained();

    // 64x64x1 fills the counter memory exactly.
    begin_phase(2);
    apply_setup($urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
                $urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
                $urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
                32'h4_0000, 32'h4_0000, 32'h4_0000, 24'h014040, 32'h1_0000);
    push_random(300, 0);
    wait_drained();

    // Largest dimensions: far more cells than the memory holds.
    begin_phase(3);
    apply_setup($urandom, $urandom, $urandom, $urandom_range(1, 32'hFFFF_FFFF),
                $urandom_range(1, 32'hFFFF_FFFF), $urandom_range(1, 32'hFFFF_FFFF),
                24'hFFFFFF, 32'h0);
    push_random(60, 0);
    wait_drained();

    // 8x8x8 grid at a random setup, with a second long hold.
    begin_phase(2);
    apply_setup($urandom_range(0, 32'h00C8_0000) - 32'h0064_0000,
                $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000,
                $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000,
                $urandom_range(32'h4000, 32'h4_0000), $urandom_range(32'h4000, 32'h4_0000),
                $urandom_range(32'h4000, 32'h4_0000), 24'h080808,
                $urandom_range(1, 32'h0010_0000));
    push_random(400, 0);
    hold_phase = phase_no;
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
